FILE: hw/rtl/fud_pkg.sv
// fud_pkg: shared types and constants for the form-urlencoded field decoder
// result word layout, batch of results per input word, character codes, hex digit decode
// no dependencies
package fud_pkg;

    localparam int MAX_RESULTS = 4;
    localparam int RES_CNT_W   = 3;
    localparam int RES_IDX_W   = 2;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       out_part;
        logic [3:0] field_index;
        logic       part_end;
    } fud_res_t;

    typedef struct packed {
        fud_res_t [MAX_RESULTS-1:0] res;
        logic [RES_CNT_W-1:0]       cnt;
    } fud_batch_t;

    // bit 4 set means not a hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
        return v;
    endfunction

endpackage

FILE: hw/rtl/fud_step.sv
// fud_step: decoder state registers and the per-word decode logic
// produces up to four results for the word held in the input register
// depends on fud_pkg
module fud_step
    import fud_pkg::*;
#(
    parameter int FIELD_CAP   = 16,
    parameter int KEY_BYTES   = 64,
    parameter int VALUE_BYTES = 256,
    parameter int CHUNK_BYTES = 512
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       new_message,
    input  logic       commit,
    output fud_batch_t batch
);

    localparam int FC_W_RAW = $clog2(FIELD_CAP + 1);
    localparam int FC_W     = (FC_W_RAW > 4) ? FC_W_RAW : 4;
    localparam int SP_W     = $clog2(CHUNK_BYTES);
    localparam int PL_MAX   = (KEY_BYTES > VALUE_BYTES) ? KEY_BYTES : VALUE_BYTES;
    localparam int PL_W     = $clog2(PL_MAX);

    localparam logic [FC_W-1:0] FC_LIMIT    = FC_W'(FIELD_CAP);
    localparam logic [SP_W-1:0] SPAN_LIMIT  = SP_W'(CHUNK_BYTES - 1);
    localparam logic [PL_W-1:0] KEY_LIMIT   = PL_W'(KEY_BYTES - 1);
    localparam logic [PL_W-1:0] VALUE_LIMIT = PL_W'(VALUE_BYTES - 1);

    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_PCT,
        ESC_HELD
    } esc_t;

    typedef struct packed {
        logic [FC_W-1:0] fc;
        logic            in_value;
        logic [7:0]      esc_char;
        esc_t            esc;
        logic [SP_W-1:0] span;
        logic [PL_W-1:0] plen;
    } state_t;

    typedef struct packed {
        state_t     st;
        fud_batch_t b;
    } work_t;

    state_t state_reg;
    state_t state_next;
    work_t  w;

    function automatic work_t emit(input work_t wi, input logic [7:0] b,
                                   input logic has, input logic pend);
        work_t r;
        r = wi;
        if (wi.b.cnt < RES_CNT_W'(MAX_RESULTS)) begin
            r.b.res[wi.b.cnt[RES_IDX_W-1:0]] = '{out_byte: b, has_byte: has,
                out_part: wi.st.in_value, field_index: wi.st.fc[3:0], part_end: pend};
            r.b.cnt = wi.b.cnt + 1'b1;
        end
        return r;
    endfunction

    function automatic work_t put_byte(input work_t wi, input logic [7:0] b);
        work_t           r;
        logic [PL_W-1:0] lim;
        r = wi;
        lim = wi.st.in_value ? VALUE_LIMIT : KEY_LIMIT;
        if (wi.st.plen < lim) begin
            r = emit(wi, b, 1'b1, 1'b0);
            r.st.plen = wi.st.plen + 1'b1;
        end
        return r;
    endfunction

    function automatic work_t plain(input work_t wi, input logic [7:0] c);
        return put_byte(wi, (c == CH_PLUS) ? CH_SPACE : c);
    endfunction

    function automatic work_t feed_idle(input work_t wi, input logic [7:0] c);
        work_t r;
        r = wi;
        if (c == CH_PCT) r.st.esc = ESC_PCT;
        else r = plain(wi, c);
        return r;
    endfunction

    function automatic work_t feed(input work_t wi, input logic [7:0] c);
        work_t      r;
        logic [4:0] hi;
        logic [4:0] lo;
        r = wi;
        hi = hex_val(wi.st.esc_char);
        lo = hex_val(c);
        case (wi.st.esc)
            ESC_NONE:
            begin
                r = feed_idle(wi, c);
            end
            ESC_PCT:
            begin
                r.st.esc_char = c;
                r.st.esc = ESC_HELD;
            end
            default:
            begin
                r.st.esc = ESC_NONE;
                if (!hi[4] && !lo[4]) begin
                    r = put_byte(r, {hi[3:0], lo[3:0]});
                end
                else begin
                    // bad escape: drop the percent, replay both characters
                    r = feed_idle(r, wi.st.esc_char);
                    if (r.st.esc == ESC_PCT) begin
                        r.st.esc_char = c;
                        r.st.esc = ESC_HELD;
                    end
                    else begin
                        r = feed_idle(r, c);
                    end
                end
            end
        endcase
        return r;
    endfunction

    function automatic work_t flush_escape(input work_t wi);
        work_t r;
        r = wi;
        if (wi.st.esc != ESC_NONE) r = put_byte(r, CH_PCT);
        if (wi.st.esc == ESC_HELD) r = plain(r, wi.st.esc_char);
        r.st.esc = ESC_NONE;
        return r;
    endfunction

    function automatic work_t finish_field(input work_t wi);
        work_t r;
        r = flush_escape(wi);
        if (!r.st.in_value) begin
            r = emit(r, 8'h00, 1'b0, 1'b1);
            r.st.in_value = 1'b1;
            r.st.plen = '0;
        end
        r = emit(r, 8'h00, 1'b0, 1'b1);
        r.st.fc = r.st.fc + 1'b1;
        return r;
    endfunction

    function automatic work_t clear_span(input work_t wi);
        work_t r;
        r = wi;
        r.st.in_value = 1'b0;
        r.st.esc_char = 8'h00;
        r.st.esc = ESC_NONE;
        r.st.span = '0;
        r.st.plen = '0;
        return r;
    endfunction

    function automatic work_t end_span(input work_t wi);
        work_t r;
        r = wi;
        // a span cut at the chunk limit was already closed
        if (wi.st.span != '0 && wi.st.span < SPAN_LIMIT && wi.st.fc < FC_LIMIT)
            r = finish_field(r);
        r = clear_span(r);
        return r;
    endfunction

    always_comb
    begin
        w.st = state_reg;
        w.b = '0;
        if (new_message) begin
            w.st.fc = '0;
            w = clear_span(w);
        end
        if (in_byte == CH_AMP) begin
            w = end_span(w);
        end
        else if (w.st.fc < FC_LIMIT && w.st.span < SPAN_LIMIT) begin
            w.st.span = w.st.span + 1'b1;
            if (!w.st.in_value && in_byte == CH_EQ) begin
                w = flush_escape(w);
                w = emit(w, 8'h00, 1'b0, 1'b1);
                w.st.in_value = 1'b1;
                w.st.plen = '0;
            end
            else begin
                w = feed(w, in_byte);
            end
            if (w.st.span == SPAN_LIMIT) w = finish_field(w);
        end
        if (in_last) w = end_span(w);
        state_next = w.st;
        batch = w.b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= '0;
        end
        else if (commit) begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hw/rtl/fud_out_queue.sv
// fud_out_queue: result register bank that holds one batch of results
// and hands them out one word per cycle while pop_ready is high, oldest first
// depends on fud_pkg
module fud_out_queue
    import fud_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  fud_batch_t load_batch,
    input  logic       pop_ready,
    output fud_res_t   head,
    output logic       head_valid,
    output logic       head_last,
    output logic       can_load
);

    fud_res_t [MAX_RESULTS-1:0] slot_reg;
    fud_res_t [MAX_RESULTS-1:0] slot_next;
    logic [RES_CNT_W-1:0]       cnt_reg;
    logic [RES_CNT_W-1:0]       cnt_next;
    logic                       pop;

    assign head_valid = (cnt_reg != '0);
    assign head_last  = (cnt_reg == RES_CNT_W'(1));
    assign head       = slot_reg[0];
    assign pop        = head_valid && pop_ready;
    // empty, or the final word of the batch leaves this cycle
    assign can_load   = !head_valid || (head_last && pop_ready);

    always_comb
    begin
        slot_next = slot_reg;
        cnt_next = cnt_reg;
        if (load) begin
            slot_next = load_batch.res;
            cnt_next = load_batch.cnt;
        end
        else if (pop) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                slot_next[i] = slot_reg[i + 1];
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= '0;
        end
        else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

FILE: hw/rtl/form_urlencoded_field_decoder_unit.sv
// path: an accepted word passes the input register, is decoded there and is loaded into
// the result bank, which raises m_tvalid; loading waits until the bank can take it
// throughput: one input word per cycle while each word yields at most one result and m_tready is high;
// a word yielding more results (up to four) is loaded at once, and the next word waits
// in the input register while the single result port drains the result register bank
// reset: rst_n clears field count, span state, the input valid flag and the result bank count
module form_urlencoded_field_decoder_unit
    import fud_pkg::*;
#(
    parameter int FIELD_CAP   = 16,
    parameter int KEY_BYTES   = 64,
    parameter int VALUE_BYTES = 256,
    parameter int CHUNK_BYTES = 512
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,
    input  logic        s_tuser,   // [0] new_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [11:8] field_index, [15:12] zero
    output logic        m_tlast,
    output logic [2:0]  m_tuser    // [0] has_byte, [1] out_part, [2] part_end
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       new_msg_reg;

    fud_batch_t batch;
    fud_res_t   head;
    logic       can_load;
    logic       fire;
    logic       load;

    assign fire     = in_valid_reg && ((batch.cnt == '0) || can_load);
    assign load     = fire && (batch.cnt != '0);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
            new_msg_reg <= s_tuser;
        end
    end

    fud_step #(
        .FIELD_CAP   (FIELD_CAP),
        .KEY_BYTES   (KEY_BYTES),
        .VALUE_BYTES (VALUE_BYTES),
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_byte     (in_byte_reg),
        .in_last     (in_last_reg),
        .new_message (new_msg_reg),
        .commit      (fire),
        .batch       (batch)
    );

    fud_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .load_batch (batch),
        .pop_ready  (m_tready),
        .head       (head),
        .head_valid (m_tvalid),
        .head_last  (m_tlast),
        .can_load   (can_load)
    );

    assign m_tdata = {4'b0000, head.field_index, head.out_byte};
    assign m_tuser = {head.part_end, head.out_part, head.has_byte};

endmodule

FILE: hw/rtl/fud_checker.sv
// fud_checker: port-level checks on the form-urlencoded field decoder
// attached to the top level by the bind at the end of this file
// no dependencies
module fud_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast,
    input logic [2:0]  m_tuser
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result word changed while stalled");

    // every result is either a decoded byte or an end marker
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser[0] != m_tuser[2])
        else $error("result is neither byte nor marker");

    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> m_tdata[7:0] == 8'h00)
        else $error("end marker carries a byte");

    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind form_urlencoded_field_decoder_unit fud_checker u_fud_checker (.*);

FILE: verif/fud_decode_checker.sv
`timescale 1ns / 1ps
// fud_decode_checker: follows raw bytes into the form-urlencoded field decoder, predicts
// each decoded word the block must emit and compares the words as they leave it
// depends on fud_pkg for character codes and the per-byte result limit
module fud_decode_checker
    import fud_pkg::*;
#(
    parameter int FIELD_CAP   = 16,
    parameter int KEY_BYTES   = 64,
    parameter int VALUE_BYTES = 256,
    parameter int CHUNK_BYTES = 512
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tlast,
    input  logic [2:0]  m_tuser,
    output int          error_count,
    output int          words_due,
    output int          words_checked
);

    localparam logic [1:0] ESC_NONE = 2'd0;
    localparam logic [1:0] ESC_PCT  = 2'd1;
    localparam logic [1:0] ESC_HELD = 2'd2;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       part;
        logic [3:0] idx;
        logic       pend;
        logic       last;
    } dec_word_t;

    dec_word_t decoded_due[$];
    dec_word_t step_words[$];

    logic [4:0] field_cnt = '0;
    logic       in_value  = 1'b0;
    logic [7:0] held_char = '0;
    logic [1:0] esc_state = ESC_NONE;
    logic [8:0] span_len  = '0;
    logic [7:0] part_len  = '0;

    int n_err     = 0;
    int n_due     = 0;
    int n_checked = 0;

    assign error_count   = n_err;
    assign words_due     = n_due;
    assign words_checked = n_checked;

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic void emit_word(input logic [7:0] b, input logic has, input logic pend);
        dec_word_t w;
        if (step_words.size() >= MAX_RESULTS) return;
        w = '{data: b, has: has, part: in_value, idx: field_cnt[3:0], pend: pend, last: 1'b0};
        step_words.push_back(w);
    endfunction

    // parts keep one byte less than their buffer size
    function automatic void put_decoded(input logic [7:0] b);
        int limit;
        limit = in_value ? VALUE_BYTES : KEY_BYTES;
        if (int'(part_len) + 1 < limit) begin
            emit_word(b, 1'b1, 1'b0);
            part_len = part_len + 8'd1;
        end
    endfunction

    function automatic void plain_char(input logic [7:0] c);
        put_decoded((c == CH_PLUS) ? CH_SPACE : c);
    endfunction

    function automatic void idle_char(input logic [7:0] c);
        if (c == CH_PCT) esc_state = ESC_PCT;
        else plain_char(c);
    endfunction

    function automatic void decode_char(input logic [7:0] c);
        int hi;
        int lo;
        if (esc_state == ESC_NONE) begin
            idle_char(c);
        end
        else if (esc_state == ESC_PCT) begin
            held_char = c;
            esc_state = ESC_HELD;
        end
        else begin
            hi = hex_digit(held_char);
            lo = hex_digit(c);
            esc_state = ESC_NONE;
            if (hi >= 0 && lo >= 0) begin
                put_decoded(8'(hi * 16 + lo));
            end
            else begin
                // drop the percent, replay both characters; either may open a new escape
                idle_char(held_char);
                if (esc_state == ESC_PCT) begin
                    held_char = c;
                    esc_state = ESC_HELD;
                end
                else begin
                    idle_char(c);
                end
            end
        end
    endfunction

    function automatic void flush_escape();
        if (esc_state != ESC_NONE) put_decoded(CH_PCT);
        if (esc_state == ESC_HELD) plain_char(held_char);
        esc_state = ESC_NONE;
    endfunction

    function automatic void clear_span();
        in_value  = 1'b0;
        held_char = '0;
        esc_state = ESC_NONE;
        span_len  = '0;
        part_len  = '0;
    endfunction

    function automatic void close_field();
        flush_escape();
        if (!in_value) begin
            emit_word(8'h00, 1'b0, 1'b1);
            in_value = 1'b1;
            part_len = '0;
        end
        emit_word(8'h00, 1'b0, 1'b1);
        field_cnt = field_cnt + 5'd1;
    endfunction

    function automatic void end_span();
        if (span_len != 0 && int'(span_len) < CHUNK_BYTES - 1 && int'(field_cnt) < FIELD_CAP)
            close_field();
        clear_span();
    endfunction

    function automatic void decode_raw_byte(input logic [7:0] b, input logic last,
                                            input logic nm);
        dec_word_t w;
        step_words.delete();
        if (nm) begin
            field_cnt = '0;
            clear_span();
        end
        if (b == CH_AMP) begin
            end_span();
        end
        else if (int'(field_cnt) < FIELD_CAP && int'(span_len) < CHUNK_BYTES - 1) begin
            span_len = span_len + 9'd1;
            if (!in_value && b == CH_EQ) begin
                flush_escape();
                emit_word(8'h00, 1'b0, 1'b1);
                in_value = 1'b1;
                part_len = '0;
            end
            else begin
                decode_char(b);
            end
            // over-long span: field closes here, rest of span is ignored
            if (int'(span_len) == CHUNK_BYTES - 1) close_field();
        end
        if (last) end_span();
        foreach (step_words[i]) begin
            w = step_words[i];
            w.last = (i == step_words.size() - 1);
            decoded_due.push_back(w);
        end
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            n_err++;
        end
    endfunction

    always @(posedge clk) begin
        dec_word_t want;
        if (rst_n) begin
            if (s_tvalid && s_tready) decode_raw_byte(s_tdata, s_tlast, s_tuser);
            if (m_tvalid && m_tready) begin
                if (decoded_due.size() == 0) begin
                    $error("unexpected word: tdata %0h tuser %0h tlast %0b",
                           m_tdata, m_tuser, m_tlast);
                    n_err++;
                end
                else begin
                    want = decoded_due.pop_front();
                    check_field("out_byte", want.data, m_tdata[7:0]);
                    check_field("field_index", want.idx, m_tdata[11:8]);
                    check_field("tdata pad", 0, m_tdata[15:12]);
                    check_field("has_byte", want.has, m_tuser[0]);
                    check_field("out_part", want.part, m_tuser[1]);
                    check_field("part_end", want.pend, m_tuser[2]);
                    check_field("out_last", want.last, m_tlast);
                    n_checked++;
                end
            end
            n_due = decoded_due.size();
        end
    end

endmodule

FILE: verif/tb_form_urlencoded_field_decoder_unit.sv
`timescale 1ns / 1ps
// tb_form_urlencoded_field_decoder_unit: feeds form payloads, noise and edge cases into the
// decoder with random gaps and output stalls; verdict from checker errors and words due
// depends on fud_pkg, form_urlencoded_field_decoder_unit and fud_decode_checker
module tb_form_urlencoded_field_decoder_unit;
    import fud_pkg::*;

    localparam int    HALF_PERIOD = 6;
    localparam int    LONG_HOLD   = 120;
    localparam string ALNUM       = "abcxyzABCXYZ0189_-.~";
    localparam string HEXD        = "0123456789abcdefABCDEF";
    localparam string NONHEX      = "gGzZ_.%+";
    localparam string SPECIALS    = "&=%+";

    typedef enum {MSG_PLAIN, MSG_NOISE, MSG_LONG_KEY, MSG_MANY_FIELDS, MSG_LONG_SPAN} msg_kind_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] in_byte
    logic        s_tlast;
    logic        s_tuser;    // [0] new_message
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // [7:0] out_byte, [11:8] field_index, [15:12] zero
    logic        m_tlast;
    logic [2:0]  m_tuser;    // [0] has_byte, [1] out_part, [2] part_end

    int error_count;
    int words_due;
    int words_checked;

    int   bytes_sent    = 0;
    int   runs_sent     = 0;
    int   holds_asked   = 0;
    int   holds_done    = 0;
    bit   tx_calm       = 1'b0;
    logic [7:0] msg_text[$];

    form_urlencoded_field_decoder_unit u_top (.*);

    fud_decode_checker u_checker (.*);

    initial clk = 1'b0;
    always #(HALF_PERIOD) clk = ~clk;

    initial begin
        #(9_600_000);
        $display("timeout with %0d decoded words still due", words_due);
        $display("tb_form_urlencoded_field_decoder_unit: done, errors");
        $finish;
    end

    function automatic int tx_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_calm || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 9);
        return $urandom_range(15, 40);
    endfunction

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_byte(input logic [7:0] b, input logic last, input logic nm);
        int gap;
        gap = tx_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        s_tuser  <= nm;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_str(input string s, input bit nm_first, input bit last_end);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], last_end && i == s.len() - 1, nm_first && i == 0);
        runs_sent++;
    endtask

    // split_ok lets payload ends and new messages fall at random bytes
    task automatic send_message(input bit split_ok);
        logic last;
        logic nm;
        for (int i = 0; i < msg_text.size(); i++) begin
            last = (i == msg_text.size() - 1) || (split_ok && $urandom_range(0, 29) == 0);
            nm   = (i == 0) || (split_ok && $urandom_range(0, 249) == 0);
            send_byte(msg_text[i], last, nm);
        end
        runs_sent++;
    endtask

    function automatic void add_unit(input bit clean);
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            msg_text.push_back(ALNUM[$urandom_range(0, ALNUM.len() - 1)]);
        end
        else if (r < 60) begin
            msg_text.push_back(CH_PLUS);
        end
        else if (r < 75) begin
            msg_text.push_back(CH_PCT);
            msg_text.push_back(HEXD[$urandom_range(0, HEXD.len() - 1)]);
            msg_text.push_back(HEXD[$urandom_range(0, HEXD.len() - 1)]);
        end
        else if (r < 82) begin
            msg_text.push_back(CH_PCT);
            if ($urandom_range(0, 1)) msg_text.push_back(HEXD[$urandom_range(0, HEXD.len() - 1)]);
            else msg_text.push_back(NONHEX[$urandom_range(0, NONHEX.len() - 1)]);
            msg_text.push_back(NONHEX[$urandom_range(0, NONHEX.len() - 1)]);
        end
        else if (clean || r < 86) begin
            msg_text.push_back(CH_PCT);
        end
        else if (r < 94) begin
            msg_text.push_back(8'($urandom_range(0, 255)));
        end
        else begin
            msg_text.push_back(CH_EQ);
        end
    endfunction

    function automatic void add_field(input int key_units, input int val_units, input bit with_eq);
        repeat (key_units) add_unit(1'b0);
        if (with_eq) msg_text.push_back(CH_EQ);
        repeat (val_units) add_unit(1'b0);
        msg_text.push_back(CH_AMP);
    endfunction

    function automatic void build_message(input msg_kind_t kind);
        msg_text.delete();
        case (kind)
            MSG_PLAIN: begin
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(0, 9) == 0) msg_text.push_back(CH_AMP);
                    else add_field($urandom_range(0, 6), $urandom_range(0, 8),
                                   $urandom_range(0, 9) != 0);
                end
                if ($urandom_range(0, 1)) void'(msg_text.pop_back());
                if (msg_text.size() == 0) msg_text.push_back(ALNUM[0]);
            end
            MSG_NOISE: begin
                repeat ($urandom_range(3, 12)) begin
                    if ($urandom_range(0, 99) < 40)
                        msg_text.push_back(SPECIALS[$urandom_range(0, SPECIALS.len() - 1)]);
                    else
                        msg_text.push_back(8'($urandom_range(0, 255)));
                end
            end
            MSG_LONG_KEY: begin
                add_field(70, 2, 1'b1);
                add_field(3, 1, 1'b1);
                add_field(1, 1, 1'b1);
            end
            MSG_MANY_FIELDS: begin
                repeat (20) add_field($urandom_range(1, 2), $urandom_range(0, 2), 1'b1);
            end
            MSG_LONG_SPAN: begin
                msg_text.push_back(ALNUM[0]);
                msg_text.push_back(CH_EQ);
                while (msg_text.size() < 530) add_unit(1'b1);
                msg_text.push_back(CH_AMP);
                add_field(2, 2, 1'b1);
            end
            default: msg_text.push_back(CH_AMP);
        endcase
    endfunction

    // output side: short and long stalls, calm stretches, and the long holds asked for
    initial begin
        int n;
        int tick;
        tick = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            tick++;
            if (holds_done < holds_asked) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                holds_done++;
            end
            else begin
                n = $urandom_range(0, 99);
                if ((tick / 150) % 3 == 0 || n < 65) begin
                    m_tready <= 1'b1;
                end
                else begin
                    m_tready <= 1'b0;
                    repeat ((n < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40))
                        @(negedge clk);
                end
            end
        end
    end

    initial begin
        msg_kind_t kind;
        int idx;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        s_tuser  = 1'b0;
        rst_n    = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // escapes, plus, separators and empty spans
        send_str("a%41=%2b+&&", 1'b1, 1'b0);
        // double percent, bad escape, percent cut by payload end
        send_str("%%41=%z%4", 1'b0, 1'b1);
        // zero byte, held plus cut by '&', top byte, new message dropping an open span
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(CH_PCT, 1'b0, 1'b0);
        send_byte(CH_PLUS, 1'b0, 1'b0);
        send_byte(CH_AMP, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte("k", 1'b1, 1'b1);
        runs_sent++;

        // directed runs at fixed indices among random payloads, until the byte budget is spent
        idx = 0;
        while (idx < 6 || bytes_sent < 300) begin
            tx_calm = ($urandom_range(0, 4) == 0);
            if (idx == 2 || idx == 7) begin
                holds_asked++;
                tx_calm = 1'b1;
            end
            case (idx)
                1:       kind = MSG_LONG_KEY;
                3:       kind = MSG_MANY_FIELDS;
                5:       kind = MSG_LONG_SPAN;
                default: kind = ($urandom_range(0, 99) < 80) ? MSG_PLAIN : MSG_NOISE;
            endcase
            build_message(kind);
            send_message(kind == MSG_PLAIN || kind == MSG_NOISE);
            idx++;
        end
        s_tvalid <= 1'b0;

        while (words_due != 0) @(negedge clk);
        repeat (10) @(negedge clk);

        $display("covered %0d raw bytes in %0d payload runs, including long keys, long spans",
                 bytes_sent, runs_sent);
        $display("and the field limit; %0d decoded words checked across %0d long output holds",
                 words_checked, holds_done);
        if (error_count == 0 && words_due == 0)
            $display("tb_form_urlencoded_field_decoder_unit: done, clean");
        else
            $display("tb_form_urlencoded_field_decoder_unit: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/fud_pkg.sv
hw/rtl/fud_step.sv
hw/rtl/fud_out_queue.sv
hw/rtl/form_urlencoded_field_decoder_unit.sv
hw/rtl/fud_checker.sv
verif/fud_decode_checker.sv
verif/tb_form_urlencoded_field_decoder_unit.sv
